// ----- sv/tcst_pkg.sv -----
// Shared types, constants and helpers of the touch contact slot tracker.
`default_nettype none

package tcst_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [1:0] {
        OP_CANCEL  = 2'd0,
        OP_PRESS   = 2'd1,
        OP_MOVE    = 2'd2,
        OP_RELEASE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_PRESSED  = 2'd0,
        KIND_AXIS     = 2'd1,
        KIND_RELEASED = 2'd2
    } t_kind;

    // Datapath actions ordered by the controller.
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_LOAD    = 3'd1,
        ACT_FREE    = 3'd2,
        ACT_RELEASE = 3'd3,
        ACT_MOVE    = 3'd4,
        ACT_PRESS   = 3'd5,
        ACT_AXIS2   = 3'd6
    } t_act;

    typedef struct packed {
        t_act act;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic has_free;
        t_op  op;
    } t_status;

    // Report the low three bits of a slot number.
    function automatic logic [2:0] slot_to_out(input logic [SLOT_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[2:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/tcst_ctrl.sv -----
// Controller state machine of the touch contact slot tracker.
`default_nettype none

module tcst_ctrl
    import tcst_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     start,
    output logic    busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LOOK  = 3'b010,
        S_EMIT2 = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd.act = ACT_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.act = ACT_LOAD;
                    n_state   = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_IDLE;
                if (i_status.hit) begin
                    unique case (i_status.op)
                        OP_CANCEL:  o_cmd.act = ACT_FREE;
                        OP_RELEASE: o_cmd.act = ACT_RELEASE;
                        OP_MOVE:    o_cmd.act = ACT_MOVE;
                        OP_PRESS:   o_cmd.act = ACT_NONE;
                        default:    o_cmd.act = ACT_NONE;
                    endcase
                end else if (i_status.has_free) begin
                    o_cmd.act = ACT_PRESS;
                    n_state   = S_EMIT2;
                end
            end
            S_EMIT2: begin
                o_cmd.act = ACT_AXIS2;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- sv/tcst_dp.sv -----
// Datapath of the touch contact slot tracker: slot table, lookup and event register.
`default_nettype none

module tcst_dp
    import tcst_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  wire  [1:0]          i_op,
    input  wire  [31:0]         i_contact_id,
    input  wire  signed [15:0]  i_pos_x,
    input  wire  signed [15:0]  i_pos_y,
    output logic                o_valid,
    output logic [1:0]          o_event_kind,
    output logic [2:0]          o_slot_index,
    output logic [31:0]         o_event_id,
    output logic signed [15:0]  o_event_x,
    output logic signed [15:0]  o_event_y,
    output logic signed [16:0]  o_delta_x,
    output logic signed [16:0]  o_delta_y,
    output logic                o_last
);

    // Latched item
    t_op         r_op;
    logic [31:0] r_id;
    logic [15:0] r_px;
    logic [15:0] r_py;

    // Slot table
    logic        r_used   [NUM_SLOTS];
    logic [31:0] r_contact[NUM_SLOTS];
    logic [15:0] r_cur_x  [NUM_SLOTS];
    logic [15:0] r_cur_y  [NUM_SLOTS];
    logic [15:0] r_prev_x [NUM_SLOTS];
    logic [15:0] r_prev_y [NUM_SLOTS];

    // Event register
    logic        r_valid;
    t_kind       r_kind;
    logic [2:0]  r_slot;
    logic [31:0] r_ev_id;
    logic [15:0] r_ev_x;
    logic [15:0] r_ev_y;
    logic [16:0] r_dx;
    logic [16:0] r_dy;
    logic        r_last;

    logic [NUM_SLOTS-1:0] hit_vec;
    logic [NUM_SLOTS-1:0] free_vec;
    logic [SLOT_W-1:0]    hit_idx;
    logic [SLOT_W-1:0]    free_idx;
    logic [15:0]          sel_cur_x;
    logic [15:0]          sel_cur_y;
    logic [16:0]          move_dx;
    logic [16:0]          move_dy;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            hit_vec[i]  = r_used[i] && (r_contact[i] == r_id);
            free_vec[i] = !r_used[i];
        end
    end

    // Find the first matching and the first free slot.
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = SLOT_W'(i);
            end
            if (free_vec[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign sel_cur_x = r_cur_x[hit_idx];
    assign sel_cur_y = r_cur_y[hit_idx];
    assign move_dx   = {r_px[15], r_px} - {sel_cur_x[15], sel_cur_x};
    assign move_dy   = {r_py[15], r_py} - {sel_cur_y[15], sel_cur_y};

    assign o_status.hit      = |hit_vec;
    assign o_status.has_free = |free_vec;
    assign o_status.op       = r_op;

    // Item latch and table payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.act)
            ACT_LOAD: begin
                r_op <= t_op'(i_op);
                r_id <= i_contact_id;
                r_px <= i_pos_x;
                r_py <= i_pos_y;
            end
            ACT_MOVE: begin
                r_prev_x[hit_idx] <= sel_cur_x;
                r_prev_y[hit_idx] <= sel_cur_y;
                r_cur_x[hit_idx]  <= r_px;
                r_cur_y[hit_idx]  <= r_py;
            end
            ACT_PRESS: begin
                r_contact[free_idx] <= r_id;
                r_cur_x[free_idx]   <= r_px;
                r_cur_y[free_idx]   <= r_py;
                r_prev_x[free_idx]  <= r_px;
                r_prev_y[free_idx]  <= r_py;
            end
            ACT_NONE, ACT_FREE, ACT_RELEASE, ACT_AXIS2: begin
            end
            default: begin
            end
        endcase
    end

    // Slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_used[i] <= 1'b0;
            end
        end else begin
            if (i_cmd.act == ACT_FREE || i_cmd.act == ACT_RELEASE) begin
                r_used[hit_idx] <= 1'b0;
            end else if (i_cmd.act == ACT_PRESS) begin
                r_used[free_idx] <= 1'b1;
            end
        end
    end

    // Event strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.act == ACT_RELEASE) || (i_cmd.act == ACT_MOVE) ||
                       (i_cmd.act == ACT_PRESS) || (i_cmd.act == ACT_AXIS2);
        end
    end

    // Event payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.act)
            ACT_RELEASE: begin
                r_kind  <= KIND_RELEASED;
                r_slot  <= slot_to_out(hit_idx);
                r_ev_id <= r_id;
                r_ev_x  <= r_prev_x[hit_idx];
                r_ev_y  <= r_prev_y[hit_idx];
                r_dx    <= '0;
                r_dy    <= '0;
                r_last  <= 1'b1;
            end
            ACT_MOVE: begin
                r_kind  <= KIND_AXIS;
                r_slot  <= slot_to_out(hit_idx);
                r_ev_id <= r_id;
                r_ev_x  <= r_px;
                r_ev_y  <= r_py;
                r_dx    <= move_dx;
                r_dy    <= move_dy;
                r_last  <= 1'b1;
            end
            ACT_PRESS: begin
                r_kind  <= KIND_PRESSED;
                r_slot  <= slot_to_out(free_idx);
                r_ev_id <= r_id;
                r_ev_x  <= r_px;
                r_ev_y  <= r_py;
                r_dx    <= '0;
                r_dy    <= '0;
                r_last  <= 1'b0;
            end
            ACT_AXIS2: begin
                // Same slot and position as the pressed event just sent.
                r_kind <= KIND_AXIS;
                r_last <= 1'b1;
            end
            ACT_NONE, ACT_LOAD, ACT_FREE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_valid      = r_valid;
    assign o_event_kind = r_kind;
    assign o_slot_index = r_slot;
    assign o_event_id   = r_ev_id;
    assign o_event_x    = r_ev_x;
    assign o_event_y    = r_ev_y;
    assign o_delta_x    = r_dx;
    assign o_delta_y    = r_dy;
    assign o_last       = r_last;

endmodule

`default_nettype wire

// ----- sv/touch_contact_slot_tracker_core.sv -----
// Top level of the touch contact slot tracker: controller plus datapath.
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  ------------------------------------------
//   item     in         start & !busy             i_op, i_contact_id, i_pos_x, i_pos_y
//   event    out        o_valid, one-cycle strobe o_event_kind, o_slot_index, o_event_id,
//                                                 o_event_x, o_event_y, o_delta_x,
//                                                 o_delta_y, o_last
//
// An item is accepted in idle and then looked up against all slots; it yields no
// event or one event, or, when it takes a new slot, pressed plus axis, the axis
// event coming from a second emit state. The lookup compares against every slot,
// picks the first match or free slot, updates that slot and loads the event register.
// Each event sits on the outputs for exactly one cycle; the receiver cannot stall,
// and the next item may be accepted while the last event is still showing.
// Synchronous active-low reset frees every slot and clears the event strobe.
`default_nettype none

module touch_contact_slot_tracker_core
    import tcst_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire  [1:0]          i_op,
    input  wire  [31:0]         i_contact_id,
    input  wire  signed [15:0]  i_pos_x,
    input  wire  signed [15:0]  i_pos_y,
    output logic                o_valid,
    output logic [1:0]          o_event_kind,
    output logic [2:0]          o_slot_index,
    output logic [31:0]         o_event_id,
    output logic signed [15:0]  o_event_x,
    output logic signed [15:0]  o_event_y,
    output logic signed [16:0]  o_delta_x,
    output logic signed [16:0]  o_delta_y,
    output logic                o_last
);

    // Commands from the controller, status back from the datapath.
    t_cmd    cmd;
    t_status status;

    // Sequence: idle -> lookup -> (second event for a new contact) -> idle.
    tcst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Hold the slot table, match the item and drive the event register.
    tcst_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_op         (i_op),
        .i_contact_id (i_contact_id),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .o_valid      (o_valid),
        .o_event_kind (o_event_kind),
        .o_slot_index (o_slot_index),
        .o_event_id   (o_event_id),
        .o_event_x    (o_event_x),
        .o_event_y    (o_event_y),
        .o_delta_x    (o_delta_x),
        .o_delta_y    (o_delta_y),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// ----- sim/touch_contact_slot_tracker_core_test.sv -----
// Self-checking testbench for the touch contact slot tracker core.
`timescale 1ns / 1ps

module touch_contact_slot_tracker_core_test;
    import tcst_pkg::*;

    // Far above the slowest correct run: about 1500 items, each taking the accept,
    // lookup and at most an emit state plus a short random gap, and a few drains.
    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_N      = 12;

    // One event the tracker is expected to report.
    typedef struct {
        t_kind              kind;
        logic [2:0]         slot;
        logic [31:0]        id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic               is_last;
    } t_touch_event;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_op;
    logic [31:0]        i_contact_id;
    logic signed [15:0] i_pos_x;
    logic signed [15:0] i_pos_y;
    logic               o_valid;
    logic [1:0]         o_event_kind;
    logic [2:0]         o_slot_index;
    logic [31:0]        o_event_id;
    logic signed [15:0] o_event_x;
    logic signed [15:0] o_event_y;
    logic signed [16:0] o_delta_x;
    logic signed [16:0] o_delta_y;
    logic               o_last;

    // Mirror of the contact table, kept in step with every accepted item.
    bit                 slot_held [NUM_SLOTS];
    logic [31:0]        slot_id   [NUM_SLOTS];
    logic signed [15:0] cur_x     [NUM_SLOTS];
    logic signed [15:0] cur_y     [NUM_SLOTS];
    logic signed [15:0] prev_x    [NUM_SLOTS];
    logic signed [15:0] prev_y    [NUM_SLOTS];

    t_touch_event pending_events[$];
    int           mismatch_count = 0;
    bit           idle_on        = 1'b1;

    // Contact ids the random traffic draws from; more ids than slots so that
    // the table fills up now and then.
    logic [31:0]  id_pool[POOL_N];

    touch_contact_slot_tracker_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_contact_id (i_contact_id),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .o_valid      (o_valid),
        .o_event_kind (o_event_kind),
        .o_slot_index (o_slot_index),
        .o_event_id   (o_event_id),
        .o_event_x    (o_event_x),
        .o_event_y    (o_event_y),
        .o_delta_x    (o_delta_x),
        .o_delta_y    (o_delta_y),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop if the tracker hangs or stops reporting.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_touch_event make_event(t_kind kind, int slot, logic [31:0] id,
                                                logic signed [15:0] x, logic signed [15:0] y,
                                                int dx, int dy, bit is_last);
        t_touch_event ev;
        ev.kind    = kind;
        ev.slot    = 3'(slot);
        ev.id      = id;
        ev.x       = x;
        ev.y       = y;
        ev.dx      = 17'(dx);
        ev.dy      = 17'(dy);
        ev.is_last = is_last;
        return ev;
    endfunction

    // Append one expected event behind those already waiting.
    function automatic void queue_expected(t_touch_event ev);
        pending_events.insert(pending_events.size(), ev);
    endfunction

    // Apply one item to the mirrored table and queue the events it causes.
    task automatic track_contact(t_op op, logic [31:0] id,
                                 logic signed [15:0] x, logic signed [15:0] y);
        int s;
        int hit;
        int free_slot;
        hit       = -1;
        free_slot = -1;
        for (s = 0; s < NUM_SLOTS; s++) begin
            if (hit < 0 && slot_held[s] && slot_id[s] == id)
                hit = s;
            if (free_slot < 0 && !slot_held[s])
                free_slot = s;
        end

        if (hit >= 0) begin
            case (op)
                OP_CANCEL: begin
                    // Free quietly; the previous position stays behind.
                    slot_held[hit] = 1'b0;
                    cur_x[hit]     = 16'hFFFF;
                    cur_y[hit]     = 16'hFFFF;
                end
                OP_RELEASE: begin
                    // Report at the previous position, then free.
                    queue_expected(make_event(KIND_RELEASED, hit, id,
                                              prev_x[hit], prev_y[hit], 0, 0, 1'b1));
                    slot_held[hit] = 1'b0;
                    cur_x[hit]     = 16'hFFFF;
                    cur_y[hit]     = 16'hFFFF;
                end
                OP_MOVE: begin
                    prev_x[hit] = cur_x[hit];
                    prev_y[hit] = cur_y[hit];
                    cur_x[hit]  = x;
                    cur_y[hit]  = y;
                    queue_expected(make_event(KIND_AXIS, hit, id, x, y,
                                              int'(x) - int'(prev_x[hit]),
                                              int'(y) - int'(prev_y[hit]), 1'b1));
                end
                default: ; // a repeated press changes nothing
            endcase
        end else if (free_slot >= 0) begin
            // Any op without a match claims the first free slot.
            slot_held[free_slot] = 1'b1;
            slot_id[free_slot]   = id;
            cur_x[free_slot]     = x;
            cur_y[free_slot]     = y;
            prev_x[free_slot]    = x;
            prev_y[free_slot]    = y;
            queue_expected(make_event(KIND_PRESSED, free_slot, id, x, y,
                                      0, 0, 1'b0));
            queue_expected(make_event(KIND_AXIS, free_slot, id, x, y,
                                      0, 0, 1'b1));
        end
        // Otherwise the table is full: drop the item.
    endtask

    // Present one item at the falling edge and hold it until the tracker takes
    // it. Start is left high, so a following call runs back to back.
    task automatic send_item(t_op op, logic [31:0] id,
                             logic signed [15:0] x, logic signed [15:0] y);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(99) < 10)
            gap = $urandom_range(1, 4);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start        = 1'b1;
        i_op         = op;
        i_contact_id = id;
        i_pos_x      = x;
        i_pos_y      = y;
        // Busy only changes at a rising edge, so its value here holds for the
        // coming edge.
        while (busy)
            @(negedge i_clk);
        track_contact(op, id, x, y);
        @(posedge i_clk);
    endtask

    // Lower start and hold off until every expected event has come out, then let
    // an item that reports nothing run to its end.
    task automatic wait_for_events();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(19))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic bit in_table(logic [31:0] id);
        int s;
        for (s = 0; s < NUM_SLOTS; s++)
            if (slot_held[s] && slot_id[s] == id)
                return 1'b1;
        return 1'b0;
    endfunction

    // Press at one corner, swing to the opposite corner and back (largest
    // deltas both ways), press again, release. Then an unmatched move and an
    // unmatched cancel, which both claim a slot.
    task automatic test_press_move_release();
        send_item(OP_PRESS,   32'h1234_5678, 16'sh8000, 16'sh7FFF);
        send_item(OP_MOVE,    32'h1234_5678, 16'sh7FFF, 16'sh8000);
        send_item(OP_MOVE,    32'h1234_5678, 16'sh8000, 16'sh7FFF);
        send_item(OP_PRESS,   32'h1234_5678, 16'sh0000, 16'sh0000);
        send_item(OP_RELEASE, 32'h1234_5678, 16'sh0011, 16'sh0022);
        send_item(OP_MOVE,    32'hA5A5_5A5A, 16'sh0100, -16'sh0100);
        send_item(OP_RELEASE, 32'hA5A5_5A5A, 16'sh0000, 16'sh0000);
        send_item(OP_CANCEL,  32'h0000_0001, 16'sh0005, 16'sh0006);
        send_item(OP_CANCEL,  32'h0000_0001, 16'sh0000, 16'sh0000);
    endtask

    // The all-ones id is an ordinary contact, since free slots carry their own flag.
    task automatic test_all_ones_id();
        send_item(OP_PRESS,  32'hFFFF_FFFF, 16'shFFFF, 16'shFFFF);
        send_item(OP_MOVE,   32'hFFFF_FFFF, 16'sh0001, 16'sh0001);
        send_item(OP_CANCEL, 32'hFFFF_FFFF, 16'sh0000, 16'sh0000);
    endtask

    // Fill every slot, check that an unmatched item is dropped, then free a
    // middle slot and see it taken again as the first free one.
    task automatic test_table_full();
        int k;
        for (k = 0; k < NUM_SLOTS; k++) begin
            id_pool[k] = (k == 0) ? 32'h0000_0000 :
                         (k == NUM_SLOTS - 1) ? 32'hFFFF_FFFE : 32'h0BAD_0000 + k;
            send_item(OP_PRESS, id_pool[k], 16'(k * 100), 16'(-k * 100));
        end
        send_item(OP_MOVE,   32'hDEAD_BEEF, 16'sh0042, 16'sh0043);
        send_item(OP_CANCEL, id_pool[3], 16'sh0000, 16'sh0000);
        id_pool[3] = 32'hC0DE_0003;
        send_item(OP_PRESS,  id_pool[3], 16'sh7FFF, 16'sh8000);
    endtask

    // Mostly press/move/release on a small set of live contacts, with some
    // cancels, repeated presses and stray ops mixed in.
    task automatic test_random_traffic(int count);
        int   n;
        int   roll;
        int   k;
        t_op  op;
        for (n = 0; n < count; n++) begin
            // Retire an id now and then, but only once it holds no slot.
            if ($urandom_range(99) < 4) begin
                k = $urandom_range(POOL_N - 1);
                if (!in_table(id_pool[k]))
                    id_pool[k] = ($urandom_range(15) == 0) ? 32'hFFFF_FFFF : $urandom();
            end
            roll = $urandom_range(99);
            if (roll < 25)
                op = OP_PRESS;
            else if (roll < 65)
                op = OP_MOVE;
            else if (roll < 87)
                op = OP_RELEASE;
            else
                op = OP_CANCEL;
            send_item(op, id_pool[$urandom_range(POOL_N - 1)], pick_coord(), pick_coord());
        end
    endtask

    // Compare each event strobe against the oldest expectation.
    always @(posedge i_clk) begin : check_events
        t_touch_event want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (o_valid !== 1'b1) begin
                $error("o_valid is unknown");
                mismatch_count++;
            end else if (pending_events.size() == 0) begin
                $error("unexpected event: kind %0d slot %0d id %h",
                       o_event_kind, o_slot_index, o_event_id);
                mismatch_count++;
            end else begin
                want = pending_events.pop_front();
                if (o_event_kind !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, o_event_kind);
                    mismatch_count++;
                end
                if (o_slot_index !== want.slot) begin
                    $error("slot_index: expected %0d, got %0d", want.slot, o_slot_index);
                    mismatch_count++;
                end
                if (o_event_id !== want.id) begin
                    $error("event_id: expected %h, got %h", want.id, o_event_id);
                    mismatch_count++;
                end
                if (o_event_x !== want.x) begin
                    $error("event_x: expected %0d, got %0d", want.x, o_event_x);
                    mismatch_count++;
                end
                if (o_event_y !== want.y) begin
                    $error("event_y: expected %0d, got %0d", want.y, o_event_y);
                    mismatch_count++;
                end
                if (o_delta_x !== want.dx) begin
                    $error("delta_x: expected %0d, got %0d", want.dx, o_delta_x);
                    mismatch_count++;
                end
                if (o_delta_y !== want.dy) begin
                    $error("delta_y: expected %0d, got %0d", want.dy, o_delta_y);
                    mismatch_count++;
                end
                if (o_last !== want.is_last) begin
                    $error("last: expected %0d, got %0d", want.is_last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : run_tests
        int s;
        for (s = 0; s < NUM_SLOTS; s++) begin
            slot_held[s] = 1'b0;
            slot_id[s]   = '0;
            cur_x[s]     = 16'hFFFF;
            cur_y[s]     = 16'hFFFF;
            prev_x[s]    = 16'hFFFF;
            prev_y[s]    = 16'hFFFF;
        end
        for (s = 0; s < POOL_N; s++)
            id_pool[s] = $urandom();

        // Drive every input from time zero, with reset held low at first.
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_op         = OP_CANCEL;
        i_contact_id = '0;
        i_pos_x      = '0;
        i_pos_y      = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_press_move_release();
        test_all_ones_id();
        test_table_full();

        test_random_traffic(500);
        // Long stretch with start held whenever an item is ready.
        idle_on = 1'b0;
        test_random_traffic(400);
        // Pause the sender until the tracker has reported everything.
        wait_for_events();
        idle_on = 1'b1;
        test_random_traffic(600);

        wait_for_events();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- touch_contact_slot_tracker_core.f -----
sv/tcst_pkg.sv
sv/tcst_ctrl.sv
sv/tcst_dp.sv
sv/touch_contact_slot_tracker_core.sv
sim/touch_contact_slot_tracker_core_test.sv
